@@ rtl/hsv_pkg.sv @@
// Shared types, constants and arithmetic helpers for the HSV to RGB converter.
package hsv_pkg;

   localparam int MID_DEPTH_DEFAULT = 4;
   localparam int OUT_DEPTH_DEFAULT = 8;

   // Hue is biased by a multiple of 360 so that it is never negative.
   localparam logic [16:0] HUE_BIAS       = 17'd33120;
   localparam logic [23:0] HUE_RECIP      = 24'd11930465;
   localparam int          HUE_RECIP_SHIFT = 32;
   localparam logic [16:0] DEG_PER_TURN   = 17'd360;
   localparam logic [8:0]  DEG_PER_SECTOR = 9'd60;
   localparam logic [9:0]  FRAC_STEP      = 10'd17;
   localparam logic [9:0]  FRAC_ROUND     = 10'd2;
   localparam logic [7:0]  CHAN_MAX       = 8'd255;

   typedef enum logic [2:0] {
      HUE_RED_YELLOW,
      HUE_YELLOW_GREEN,
      HUE_GREEN_CYAN,
      HUE_CYAN_BLUE,
      HUE_BLUE_MAGENTA,
      HUE_MAGENTA_RED
   } hsv_sector_type;

   typedef struct packed {
      hsv_sector_type sector;
      logic [7:0]     frac;
      logic [7:0]     sat;
      logic [7:0]     val;
   } hsv_job_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hsv_rgb_type;

   function automatic logic [7:0] clamp_channel(input logic signed [15:0] x);
      logic [7:0] result;
      if (x < 16'sd0) begin
         result = 8'd0;
      end else if (x > 16'sd255) begin
         result = CHAN_MAX;
      end else begin
         result = x[7:0];
      end
      return result;
   endfunction

   // Rounded product scaling by 1/255 for products of two 8-bit values.
   function automatic logic [7:0] scale_255(input logic [15:0] prod);
      logic [16:0] biased;
      logic [16:0] acc;
      biased = {1'b0, prod} + 17'd127;
      acc    = biased + {8'd0, biased[16:8]} + 17'd1;
      return acc[15:8];
   endfunction

endpackage

@@ rtl/hsv_fifo.sv @@
// Small register-based first-in first-out queue of packed words.
module hsv_fifo #(
   parameter int DEPTH = hsv_pkg::MID_DEPTH_DEFAULT,
   parameter int WIDTH = $bits(hsv_pkg::hsv_job_type)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         rd_en,
   output logic [WIDTH-1:0]             rd_data,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   import hsv_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && full))
      else $error("Word written into a full queue.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && empty))
      else $error("Word read from an empty queue.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en && !rd_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("Queue count did not follow a lone write.");

endmodule

@@ rtl/hsv_front.sv @@
// Front end: takes input words, clamps channels and splits hue into sector and fraction.
module hsv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic signed [15:0]   hue,
   input  logic signed [15:0]   saturation,
   input  logic signed [15:0]   brightness,
   output logic                 job_write,
   output hsv_pkg::hsv_job_type job,
   input  logic                 mid_full
);
   import hsv_pkg::*;

   logic [16:0]    hue_sum;
   logic [16:0]    hue_biased;
   logic [40:0]    recip_prod;
   logic           take;

   logic           valid_ff, valid_in;
   logic [16:0]    hue_ff;
   logic [7:0]     quot_ff;
   logic [7:0]     sat_ff;
   logic [7:0]     val_ff;

   logic [16:0]    turns;
   logic [16:0]    deg_wide;
   logic [8:0]     deg;
   logic [8:0]     base;
   logic [8:0]     rem_wide;
   logic [9:0]     frac_sum;
   hsv_sector_type sector;

   assign hue_sum    = {hue[15], hue} + HUE_BIAS;
   assign hue_biased = hue_sum;
   assign recip_prod = hue_biased * HUE_RECIP;

   assign full      = valid_ff && mid_full;
   assign take      = push && !full;
   assign job_write = valid_ff && !mid_full;
   assign valid_in  = take || (valid_ff && mid_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hue_ff  <= hue_biased;
         quot_ff <= recip_prod[HUE_RECIP_SHIFT +: 8];
         sat_ff  <= clamp_channel(saturation);
         val_ff  <= clamp_channel(brightness);
      end
   end

   assign turns    = {9'd0, quot_ff} * DEG_PER_TURN;
   assign deg_wide = hue_ff - turns;
   assign deg      = deg_wide[8:0];

   always_comb begin
      if (deg < DEG_PER_SECTOR) begin
         sector = HUE_RED_YELLOW;
         base   = 9'd0;
      end else if (deg < 9'd120) begin
         sector = HUE_YELLOW_GREEN;
         base   = 9'd60;
      end else if (deg < 9'd180) begin
         sector = HUE_GREEN_CYAN;
         base   = 9'd120;
      end else if (deg < 9'd240) begin
         sector = HUE_CYAN_BLUE;
         base   = 9'd180;
      end else if (deg < 9'd300) begin
         sector = HUE_BLUE_MAGENTA;
         base   = 9'd240;
      end else begin
         sector = HUE_MAGENTA_RED;
         base   = 9'd300;
      end
   end

   assign rem_wide = deg - base;
   assign frac_sum = {4'd0, rem_wide[5:0]} * FRAC_STEP + FRAC_ROUND;

   assign job.sector = sector;
   assign job.frac   = frac_sum[9:2];
   assign job.sat    = sat_ff;
   assign job.val    = val_ff;

endmodule

@@ rtl/hsv_back.sv @@
// Back end: product pipeline that turns a classified word into an RGB color.
module hsv_back #(
   parameter int OUT_DEPTH = hsv_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             mid_empty,
   input  hsv_pkg::hsv_job_type             job,
   output logic                             job_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
   output logic                             rgb_write,
   output hsv_pkg::hsv_rgb_type             rgb
);
   import hsv_pkg::*;

   localparam int CW  = $clog2(OUT_DEPTH + 1);
   localparam int CW2 = CW + 2;
   localparam logic [CW2-1:0] SLOT_LIMIT = CW2'(OUT_DEPTH);

   logic [1:0]     inflight;
   logic [CW2-1:0] committed;

   logic           s1_valid_ff;
   hsv_sector_type s1_sector_ff;
   logic [7:0]     s1_val_ff;
   logic [15:0]    s1_pprod_ff, s1_qprod_ff, s1_tprod_ff;

   logic           s2_valid_ff;
   hsv_sector_type s2_sector_ff;
   logic [7:0]     s2_val_ff, s2_p_ff, s2_qfac_ff, s2_tfac_ff;

   logic           s3_valid_ff;
   hsv_sector_type s3_sector_ff;
   logic [7:0]     s3_val_ff, s3_p_ff;
   logic [15:0]    s3_qprod_ff, s3_tprod_ff;

   logic [7:0]     q_chan, t_chan;

   assign inflight  = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};
   assign committed = {2'b00, out_count} + {{CW{1'b0}}, inflight};
   assign job_pop   = !mid_empty && (committed < SLOT_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= job_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_sector_ff <= job.sector;
      s1_val_ff    <= job.val;
      s1_pprod_ff  <= job.val * (CHAN_MAX - job.sat);
      s1_qprod_ff  <= job.sat * job.frac;
      s1_tprod_ff  <= job.sat * (CHAN_MAX - job.frac);

      s2_sector_ff <= s1_sector_ff;
      s2_val_ff    <= s1_val_ff;
      s2_p_ff      <= scale_255(s1_pprod_ff);
      s2_qfac_ff   <= CHAN_MAX - scale_255(s1_qprod_ff);
      s2_tfac_ff   <= CHAN_MAX - scale_255(s1_tprod_ff);

      s3_sector_ff <= s2_sector_ff;
      s3_val_ff    <= s2_val_ff;
      s3_p_ff      <= s2_p_ff;
      s3_qprod_ff  <= s2_val_ff * s2_qfac_ff;
      s3_tprod_ff  <= s2_val_ff * s2_tfac_ff;
   end

   assign q_chan    = scale_255(s3_qprod_ff);
   assign t_chan    = scale_255(s3_tprod_ff);
   assign rgb_write = s3_valid_ff;

   always_comb begin
      unique case (s3_sector_ff)
         HUE_RED_YELLOW:   rgb = '{red: s3_val_ff, green: t_chan,    blue: s3_p_ff};
         HUE_YELLOW_GREEN: rgb = '{red: q_chan,    green: s3_val_ff, blue: s3_p_ff};
         HUE_GREEN_CYAN:   rgb = '{red: s3_p_ff,   green: s3_val_ff, blue: t_chan};
         HUE_CYAN_BLUE:    rgb = '{red: s3_p_ff,   green: q_chan,    blue: s3_val_ff};
         HUE_BLUE_MAGENTA: rgb = '{red: t_chan,    green: s3_p_ff,   blue: s3_val_ff};
         default:          rgb = '{red: s3_val_ff, green: s3_p_ff,   blue: q_chan};
      endcase
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      committed <= SLOT_LIMIT)
      else $error("More words in flight than the result queue can hold.");

endmodule

@@ rtl/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: front end, job queue, back end and result queue.
//
//   Channel   Ports                                   Handshake
//   request   req_hue, req_saturation, req_brightness push / full
//   response  rsp_red, rsp_green, rsp_blue            empty / pop
//
// One word is accepted and one color delivered per clock cycle when neither side stalls.
// Each accepted word passes the front-end register, job queue, product stages and result queue.
// The front end, the job queue and the three-stage product pipeline each hold words;
// the back end takes a job only when the result queue has room for everything in flight.
// Synchronous reset empties both queues and the pipeline; no clearing pass is needed.
module hsv_to_rgb_converter #(
   parameter int MID_DEPTH = hsv_pkg::MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH = hsv_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_hue,
   input  logic signed [15:0] req_saturation,
   input  logic signed [15:0] req_brightness,
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue
);
   import hsv_pkg::*;

   localparam int OCW = $clog2(OUT_DEPTH + 1);

   logic        job_write;
   hsv_job_type front_job;
   logic        mid_full;
   logic        mid_empty;
   hsv_job_type mid_job;
   logic        job_pop;
   logic [OCW-1:0] out_count;
   logic        rgb_write;
   hsv_rgb_type back_rgb;
   hsv_rgb_type out_rgb;
   logic        out_read;

   hsv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .job_write  (job_write),
      .job        (front_job),
      .mid_full   (mid_full)
   );

   hsv_fifo #(
      .DEPTH (MID_DEPTH),
      .WIDTH ($bits(hsv_job_type))
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_write),
      .wr_data (front_job),
      .rd_en   (job_pop),
      .rd_data (mid_job),
      .full    (mid_full),
      .empty   (mid_empty),
      .count   ()
   );

   hsv_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .job       (mid_job),
      .job_pop   (job_pop),
      .out_count (out_count),
      .rgb_write (rgb_write),
      .rgb       (back_rgb)
   );

   assign out_read = pop && !empty;

   hsv_fifo #(
      .DEPTH (OUT_DEPTH),
      .WIDTH ($bits(hsv_rgb_type))
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rgb_write),
      .wr_data (back_rgb),
      .rd_en   (out_read),
      .rd_data (out_rgb),
      .full    (),
      .empty   (empty),
      .count   (out_count)
   );

   assign rsp_red   = out_rgb.red;
   assign rsp_green = out_rgb.green;
   assign rsp_blue  = out_rgb.blue;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the HSV to RGB converter with randomized stalls on both queues.
`timescale 1ns / 1ps

module testbench;
   import hsv_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_WORDS = 850;
   localparam int SETTLE_CYCLES = 20;

   class color_scoreboard;
      hsv_rgb_type expected_colors[$];
      int errors = 0;

      function int round_div255(int a, int b);
         return (a * b + 127) / 255;
      endfunction

      function int clamp_byte(logic signed [15:0] x);
         int v;
         v = x;
         if (v < 0) begin
            v = 0;
         end else if (v > 255) begin
            v = 255;
         end
         return v;
      endfunction

      function hsv_rgb_type hsv_to_color(logic signed [15:0] hue, logic signed [15:0] sat_in,
                                         logic signed [15:0] bri_in);
         hsv_rgb_type color;
         hsv_sector_type sector;
         int sat, val, deg, frac, p, q, t;
         sat = clamp_byte(sat_in);
         val = clamp_byte(bri_in);
         deg = int'(hue) % 360;
         if (deg < 0) begin
            deg = deg + 360;
         end
         sector = hsv_sector_type'(deg / 60);
         frac = ((deg % 60) * 255 + 30) / 60;
         p = round_div255(val, 255 - sat);
         q = round_div255(val, 255 - round_div255(sat, frac));
         t = round_div255(val, 255 - round_div255(sat, 255 - frac));
         case (sector)
            HUE_RED_YELLOW: begin
               color = '{red: 8'(val), green: 8'(t), blue: 8'(p)};
            end
            HUE_YELLOW_GREEN: begin
               color = '{red: 8'(q), green: 8'(val), blue: 8'(p)};
            end
            HUE_GREEN_CYAN: begin
               color = '{red: 8'(p), green: 8'(val), blue: 8'(t)};
            end
            HUE_CYAN_BLUE: begin
               color = '{red: 8'(p), green: 8'(q), blue: 8'(val)};
            end
            HUE_BLUE_MAGENTA: begin
               color = '{red: 8'(t), green: 8'(p), blue: 8'(val)};
            end
            default: begin
               color = '{red: 8'(val), green: 8'(p), blue: 8'(q)};
            end
         endcase
         return color;
      endfunction

      function void report(string what, int want, int got);
         if (errors < 100) begin
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
         end
         errors++;
      endfunction

      function void note_word(logic signed [15:0] hue, logic signed [15:0] sat,
                              logic signed [15:0] bri);
         expected_colors.push_back(hsv_to_color(hue, sat, bri));
      endfunction

      function void check_color(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         hsv_rgb_type want;
         if (expected_colors.size() == 0) begin
            report("unexpected color, red", 0, red);
         end else begin
            want = expected_colors.pop_front();
            if (red !== want.red) begin
               report("red", want.red, red);
            end
            if (green !== want.green) begin
               report("green", want.green, green);
            end
            if (blue !== want.blue) begin
               report("blue", want.blue, blue);
            end
         end
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction

      function void check_drained();
         if (expected_colors.size() != 0) begin
            report("colors never delivered", 0, expected_colors.size());
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic signed [15:0] req_hue = '0;
   logic signed [15:0] req_saturation = '0;
   logic signed [15:0] req_brightness = '0;
   logic empty;
   logic pop = 1'b0;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;

   bit quiet = 1'b0;
   bit hold_rsp = 1'b0;
   color_scoreboard sb = new();

   hsv_to_rgb_converter dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_hue(req_hue),
      .req_saturation(req_saturation),
      .req_brightness(req_brightness),
      .empty(empty),
      .pop(pop),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && push && !full) begin
         sb.note_word(req_hue, req_saturation, req_brightness);
      end
      if (!reset && pop && !empty) begin
         sb.check_color(rsp_red, rsp_green, rsp_blue);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL hsv_to_rgb_converter");
      $finish;
   end

   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            pop <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic send_word(input int hue, input int sat, input int bri);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
      @(negedge clock);
      push <= 1'b1;
      req_hue <= 16'(hue);
      req_saturation <= 16'(sat);
      req_brightness <= 16'(bri);
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic int pick_level();
      int v;
      case ($urandom_range(0, 4))
         0: v = int'($signed(16'($urandom())));
         1, 2: v = $urandom_range(0, 255);
         3: v = $urandom_range(0, 1) ? 255 : 0;
         default: v = int'($urandom_range(0, 600)) - 300;
      endcase
      return v;
   endfunction

   function automatic int pick_hue();
      int v;
      case ($urandom_range(0, 3))
         0: v = int'($signed(16'($urandom())));
         1: v = $urandom_range(0, 359);
         2: v = int'($urandom_range(0, 1440)) - 720;
         default: v = 60 * (int'($urandom_range(0, 24)) - 12) + int'($urandom_range(0, 2)) - 1;
      endcase
      return v;
   endfunction

   initial begin
      int i;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sector edges, hue wrap, clamping of saturation and value, and grey.
      send_word(0, 255, 255);
      send_word(60, 255, 255);
      send_word(120, 255, 255);
      send_word(180, 255, 255);
      send_word(240, 255, 255);
      send_word(300, 255, 255);
      send_word(359, 255, 255);
      send_word(360, 255, 255);
      send_word(-1, 255, 255);
      send_word(-360, 200, 128);
      send_word(-32768, 255, 255);
      send_word(32767, 255, 255);
      send_word(30, 255, 255);
      send_word(90, 128, 200);
      send_word(59, 77, 250);
      send_word(45, 0, 200);
      send_word(200, -1, -1);
      send_word(200, -32768, 32767);
      send_word(200, 256, 300);
      send_word(200, 32767, -32768);
      send_word(150, 1, 1);
      send_word(-32767, 100, 255);
      send_word(270, 255, 0);
      wait_drained();

      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 300) begin
            hold_rsp = 1'b1;
         end
         if (i == 550) begin
            wait_drained();
         end
         if (i == RANDOM_WORDS - 150) begin
            quiet = 1'b1;
         end
         send_word(pick_hue(), pick_level(), pick_level());
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.check_drained();
      if (sb.errors == 0) begin
         $display("PASS hsv_to_rgb_converter");
      end else begin
         $display("FAIL hsv_to_rgb_converter");
      end
      $finish;
   end

endmodule
